// File: hdl/pdhs_pkg.sv
`timescale 1ns / 1ps
package pdhs_pkg;

    localparam int unsigned BucketsDefault  = 4096;
    localparam int unsigned CapacityDefault = 8192;

    localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ExpAll  = 64'h7FF0_0000_0000_0000;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_ABSENT   = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        op_t         op;
        logic [63:0] x_bits;
        logic [63:0] y_bits;
    } in_beat_t;

    typedef struct packed {
        status_t     status;
        logic [12:0] point_index;
    } out_beat_t;

    // hashed work handed from front to back
    typedef struct packed {
        op_t         op;
        logic [63:0] x_bits;
        logic [63:0] y_bits;
        logic [31:0] mix;
    } job_t;

    // one round of the one-at-a-time mix
    function automatic logic [31:0] oat_round(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] t;
        begin
            t = h + {{24{b[7]}}, b};
            t = t + (t << 10);
            t = t ^ (t >> 6);
            return t;
        end
    endfunction

    function automatic logic [31:0] oat_final(input logic [31:0] h);
        logic [31:0] t;
        begin
            t = h + (h << 3);
            t = t ^ (t >> 11);
            t = t + (t << 15);
            return t;
        end
    endfunction

    function automatic logic ieee_eq(input logic [63:0] a, input logic [63:0] b);
        logic nan_a;
        logic nan_b;
        begin
            nan_a = (a & ~SignBit) > ExpAll;
            nan_b = (b & ~SignBit) > ExpAll;
            return !nan_a && !nan_b && ((a == b) || (((a | b) & ~SignBit) == 64'd0));
        end
    endfunction

endpackage

// File: hdl/point_dedup_hash_set.sv
`timescale 1ns / 1ps
// channel  direction  payload     handshake
// in       input      in_beat_t   in_valid / in_stall
// out      output     out_beat_t  out_valid / out_stall
//
// in the front a point goes through accept, eight byte rounds and hand-off to the queue.
// the back reads the bucket head (HEAD, LINK) and each chain entry compared (READ, CMP); a match goes
// straight to out, otherwise READ closes the walk and WRITE stores an insert that has room, before the result beat.
// the front hashes the next point while the back walks a chain; a two-beat queue sits between.
// after reset the back clears the bucket heads; in stalls once the queue fills.
// a result holds on out until taken; the back then stalls its queue.
module point_dedup_hash_set #(
    parameter int unsigned BUCKETS  = pdhs_pkg::BucketsDefault,
    parameter int unsigned CAPACITY = pdhs_pkg::CapacityDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pdhs_pkg::in_beat_t  in_beat,
    output logic                out_valid,
    input  logic                out_stall,
    output pdhs_pkg::out_beat_t out_beat
);
    import pdhs_pkg::*;

    job_t f_job, q_job;
    logic f_valid, f_stall, q_valid, q_stall;

    pdhs_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_beat(in_beat), .job_valid(f_valid), .job_stall(f_stall), .job(f_job));

    pdhs_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_stall(f_stall), .wr_job(f_job),
        .rd_valid(q_valid), .rd_stall(q_stall), .rd_job(q_job));

    pdhs_back #(.BUCKETS(BUCKETS), .CAPACITY(CAPACITY)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(q_valid), .job_stall(q_stall), .job(q_job),
        .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat));

endmodule

// File: hdl/pdhs_ram.sv
`timescale 1ns / 1ps
module pdhs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hdl/pdhs_front.sv
`timescale 1ns / 1ps
module pdhs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  pdhs_pkg::in_beat_t in_beat,
    output logic              job_valid,
    input  logic              job_stall,
    output pdhs_pkg::job_t    job
);
    import pdhs_pkg::*;

    // x and y hashed together, one byte of each per cycle
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [2:0]  byte_reg, byte_next;
    logic [31:0] hx_reg, hx_next;
    logic [31:0] hy_reg, hy_next;
    in_beat_t    item_reg;
    logic [31:0] fx;
    logic [31:0] fy;

    assign in_stall  = busy_reg || done_reg;
    assign job_valid = done_reg;
    assign fx = oat_final(hx_reg);
    assign fy = oat_final(hy_reg);
    assign job.op = item_reg.op;
    assign job.x_bits = item_reg.x_bits;
    assign job.y_bits = item_reg.y_bits;
    assign job.mix = (fx + (fx << 1)) + fy;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        byte_next = byte_reg;
        hx_next   = hx_reg;
        hy_next   = hy_reg;
        if (in_valid && !in_stall)
        begin
            busy_next = 1'b1;
            byte_next = 3'd0;
            hx_next   = 32'd0;
            hy_next   = 32'd0;
        end
        else if (busy_reg)
        begin
            hx_next   = oat_round(hx_reg, item_reg.x_bits[{byte_reg, 3'b000} +: 8]);
            hy_next   = oat_round(hy_reg, item_reg.y_bits[{byte_reg, 3'b000} +: 8]);
            byte_next = byte_reg + 3'd1;
            if (byte_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (done_reg && !job_stall)
        begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            byte_reg <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            byte_reg <= byte_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hx_reg <= hx_next;
        hy_reg <= hy_next;
        if (in_valid && !in_stall)
        begin
            item_reg <= in_beat;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(busy_reg && done_reg))
        else $error("front busy and done together");
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && byte_reg == 3'd7) |=> done_reg)
        else $error("hash did not finish after eight rounds");
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && job_stall) |=> done_reg)
        else $error("job dropped while stalled");

endmodule

// File: hdl/pdhs_queue.sv
`timescale 1ns / 1ps
module pdhs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_stall,
    input  pdhs_pkg::job_t wr_job,
    output logic           rd_valid,
    input  logic           rd_stall,
    output pdhs_pkg::job_t rd_job
);
    import pdhs_pkg::*;

    // two entries, registers only
    job_t slot_reg [2];
    logic [1:0] fill_reg, fill_next;
    logic       head_reg, head_next;
    logic       tail_reg, tail_next;
    logic       push, pop;

    assign wr_stall = (fill_reg == 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_job   = slot_reg[head_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    always_comb
    begin
        fill_next = fill_reg + {1'b0, push} - {1'b0, pop};
        head_next = head_reg ^ pop;
        tail_next = tail_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
            head_reg <= 1'b0;
            tail_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= wr_job;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) fill_reg != 2'd3)
        else $error("queue fill out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd2) |-> (head_reg == tail_reg))
        else $error("queue pointers disagree with fill");

endmodule

// File: hdl/pdhs_back.sv
`timescale 1ns / 1ps
module pdhs_back #(
    parameter int unsigned BUCKETS  = pdhs_pkg::BucketsDefault,
    parameter int unsigned CAPACITY = pdhs_pkg::CapacityDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_stall,
    input  pdhs_pkg::job_t     job,
    output logic               out_valid,
    input  logic               out_stall,
    output pdhs_pkg::out_beat_t out_beat
);
    import pdhs_pkg::*;

    localparam int unsigned BW = $clog2(BUCKETS);
    localparam int unsigned CW = $clog2(CAPACITY);
    localparam int unsigned LW = CW + 1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_HEAD  = 8'b0000_0100,
        S_LINK  = 8'b0000_1000,
        S_READ  = 8'b0001_0000,
        S_CMP   = 8'b0010_0000,
        S_WRITE = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic [BW-1:0] clr_reg, clr_next;
    logic [LW-1:0] count_reg, count_next;
    logic [LW-1:0] link_reg, link_next;
    logic [BW-1:0] bucket_reg;
    job_t        job_reg;
    out_beat_t   res_reg, res_next;

    logic          hd_we;
    logic [BW-1:0] hd_wa, hd_ra;
    logic [LW-1:0] hd_wd, hd_rd;
    logic          pt_we;
    logic [CW-1:0] pt_ra;
    logic [63:0]   px_rd, py_rd;
    logic [LW-1:0] nx_rd;
    logic [LW-1:0] idx_full;
    logic          take;

    assign take      = job_valid && !job_stall;
    assign job_stall = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_beat  = res_reg;
    assign idx_full  = link_reg - LW'(1);

    pdhs_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head (
        .clk(clk), .wr_en(hd_we), .wr_addr(hd_wa), .wr_data(hd_wd),
        .rd_addr(hd_ra), .rd_data(hd_rd));
    pdhs_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_px (
        .clk(clk), .wr_en(pt_we), .wr_addr(count_reg[CW-1:0]), .wr_data(job_reg.x_bits),
        .rd_addr(pt_ra), .rd_data(px_rd));
    pdhs_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_py (
        .clk(clk), .wr_en(pt_we), .wr_addr(count_reg[CW-1:0]), .wr_data(job_reg.y_bits),
        .rd_addr(pt_ra), .rd_data(py_rd));
    pdhs_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next (
        .clk(clk), .wr_en(pt_we), .wr_addr(count_reg[CW-1:0]), .wr_data(hd_rd),
        .rd_addr(pt_ra), .rd_data(nx_rd));

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        count_next = count_reg;
        link_next  = link_reg;
        res_next   = res_reg;
        hd_we = 1'b0;
        hd_wa = bucket_reg;
        hd_wd = count_reg + LW'(1);
        hd_ra = bucket_reg;
        pt_we = 1'b0;
        pt_ra = idx_full[CW-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                hd_we = 1'b1;
                hd_wa = clr_reg;
                hd_wd = '0;
                clr_next = clr_reg + BW'(1);
                if (clr_reg == BW'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                // head read issued on bucket_reg
                state_next = S_LINK;
            end
            S_LINK:
            begin
                link_next  = hd_rd;
                state_next = S_READ;
            end
            S_READ:
            begin
                // link_reg valid: issue store read or finish
                if (link_reg == '0)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (ieee_eq(px_rd, job_reg.x_bits) && ieee_eq(py_rd, job_reg.y_bits))
                begin
                    res_next.status      = ST_FOUND;
                    res_next.point_index = 13'(idx_full);
                    state_next = S_OUT;
                end
                else
                begin
                    link_next  = nx_rd;
                    state_next = S_READ;
                end
            end
            S_WRITE:
            begin
                res_next.point_index = '0;
                if (job_reg.op == OP_LOOKUP)
                begin
                    res_next.status = ST_ABSENT;
                end
                else if (count_reg >= LW'(CAPACITY))
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    // hd_rd still holds the old head for the chain link
                    pt_we = 1'b1;
                    hd_we = 1'b1;
                    res_next.status      = ST_INSERTED;
                    res_next.point_index = 13'(count_reg);
                    count_next = count_reg + LW'(1);
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        link_reg <= link_next;
        res_reg  <= res_next;
        if (take)
        begin
            job_reg    <= job;
            bucket_reg <= job.mix[BW-1:0];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= LW'(CAPACITY))
        else $error("count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(res_reg)))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        pt_we |=> (count_reg == $past(count_reg) + LW'(1)))
        else $error("insert did not advance count");

endmodule
